FILE: hw/rtl/rzm_pkg.sv
// Shared types and constants for the rotate-and-zoom texture mapper.
`timescale 1ns / 1ps

package rzm_pkg;

  // Fraction bits of the rotated coordinate: Q3.16 times half-pixel units.
  localparam int unsigned FracBits = 17;
  localparam int unsigned ScreenW  = 12;
  localparam int unsigned CenterW  = 13;
  localparam int unsigned CoefW    = 20;
  localparam int unsigned DeltaW   = 14;
  localparam int unsigned ProdW    = DeltaW + CoefW;
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned TexAddrW = 16;
  localparam int unsigned TexelW   = 32;
  localparam int unsigned OutCoordW = 8;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegCenterX = 2'd0;
  localparam logic [1:0] RegCenterY = 2'd1;
  localparam logic [1:0] RegCos     = 2'd2;
  localparam logic [1:0] RegSin     = 2'd3;

  typedef enum logic {
    OpWrite  = 1'b0,
    OpRender = 1'b1
  } op_e;

  // Fields of an item that travel unchanged down the coordinate pipeline.
  typedef struct packed {
    op_e                 op;
    logic [TexAddrW-1:0] addr;
    logic [TexelW-1:0]   value;
  } tex_cmd_t;

  typedef struct packed {
    logic [CenterW-1:0]      center_x;
    logic [CenterW-1:0]      center_y;
    logic signed [CoefW-1:0] cos_z;
    logic signed [CoefW-1:0] sin_z;
  } cfg_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

endpackage

FILE: hw/rtl/rotate_zoom_texture_mapper_core.sv
// Top level of the rotate-and-zoom texture mapper.
//
//   channel  | dir | signals                        | contents
//   ---------+-----+--------------------------------+------------------------------------
//   s_axis   | in  | tvalid tready tdata tuser      | texel write or pixel render item
//   m_axis   | out | tvalid tready tdata            | sampled texel with its column, row
//   apb      | in  | psel penable pwrite paddr ...  | screen center, cos/zoom, sin/zoom
//
// One item is accepted every cycle unless the output stalls. A render result then passes
// through the coordinate stages to the output: the accepting edge loads the first of
// the three coordinate stages, and the registered read of the texture memory adds
// the last register. Writes take the same path and update the memory in order with
// renders. Reset clears the pipeline and the registers; the texture contents are
// undefined until written. A stalled output holds the output register and the item
// in the last coordinate stage, earlier stages keep filling, and the input stalls
// once all three stages hold items.
`timescale 1ns / 1ps

module rotate_zoom_texture_mapper_core import rzm_pkg::*; #(
  parameter int unsigned TEX_SIZE_LOG2 = 8,
  parameter int unsigned COORD_BITS    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // texel_address[15:0], texel_value[47:16], screen_x[59:48], screen_y[71:60]
  input  logic [71:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color[31:0], texel_column[39:32], texel_row[47:40]
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = (2 * TEX_SIZE_LOG2 > TexAddrW) ? TexAddrW
                                                                 : 2 * TEX_SIZE_LOG2;

  cfg_t cfg;
  tex_cmd_t in_cmd, cmd3;
  logic v3, r4, fire3;
  logic [TEX_SIZE_LOG2-1:0] col3, row3;
  logic [2*TEX_SIZE_LOG2-1:0] tex_idx;
  logic wr_in_range;
  mem_ctrl_t mem_ctrl;
  logic [AddrW-1:0] mem_addr;
  logic [TexelW-1:0] rdata;
  logic out_valid_q, out_valid_d;
  logic [OutCoordW-1:0] col_q, row_q;

  assign in_cmd.op    = op_e'(s_axis_tuser);
  assign in_cmd.addr  = s_axis_tdata[15:0];
  assign in_cmd.value = s_axis_tdata[47:16];

  rzm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rzm_coord #(
    .TEX_SIZE_LOG2 (TEX_SIZE_LOG2),
    .COORD_BITS    (COORD_BITS)
  ) u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (in_cmd),
    .screen_x_i  (s_axis_tdata[59:48]),
    .screen_y_i  (s_axis_tdata[71:60]),
    .cfg_i       (cfg),
    .out_valid_o (v3),
    .out_ready_i (r4),
    .out_cmd_o   (cmd3),
    .col_o       (col3),
    .row_o       (row3)
  );

  assign r4    = !out_valid_q || m_axis_tready;
  assign fire3 = v3 && r4;

  // Writes beyond the texture would alias onto real texels, so they are dropped.
  assign wr_in_range = (TexAddrW'(cmd3.addr >> AddrW) == '0);
  assign tex_idx     = {row3, col3};

  assign mem_ctrl.we = fire3 && (cmd3.op == OpWrite) && wr_in_range;
  assign mem_ctrl.re = fire3 && (cmd3.op == OpRender);
  assign mem_addr    = (cmd3.op == OpWrite) ? cmd3.addr[AddrW-1:0] : tex_idx[AddrW-1:0];

  rzm_texmem #(
    .ADDR_W (AddrW)
  ) u_texmem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (cmd3.value),
    .rdata_o (rdata)
  );

  assign out_valid_d = r4 ? mem_ctrl.re : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctrl.re) begin
      col_q <= OutCoordW'(col3);
      row_q <= OutCoordW'(row3);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {row_q, col_q, rdata};

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire3 && (cmd3.op == OpWrite) |=> !m_axis_tvalid)
    else $error("texel write produced a result item");

  a_render_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire3 && (cmd3.op == OpRender) |=> m_axis_tvalid)
    else $error("render item did not reach the output");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");
`endif

endmodule

FILE: hw/rtl/rzm_cfg.sv
// APB configuration registers: screen center and rotation coefficients.
`timescale 1ns / 1ps

module rzm_cfg import rzm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegCenterX: cfg_d.center_x = pwdata[CenterW-1:0];
        RegCenterY: cfg_d.center_y = pwdata[CenterW-1:0];
        RegCos:     cfg_d.cos_z    = pwdata[CoefW-1:0];
        RegSin:     cfg_d.sin_z    = pwdata[CoefW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= CenterW'(800);
      cfg_q.center_y <= CenterW'(600);
      cfg_q.cos_z    <= CoefW'(65536);
      cfg_q.sin_z    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegCenterX: prdata = 32'(cfg_q.center_x);
      RegCenterY: prdata = 32'(cfg_q.center_y);
      RegCos:     prdata = 32'(cfg_q.cos_z);
      RegSin:     prdata = 32'(cfg_q.sin_z);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/rzm_coord.sv
// Three-stage pipeline from screen pixel to wrapped texture column and row.
`timescale 1ns / 1ps

module rzm_coord import rzm_pkg::*; #(
  parameter int unsigned TEX_SIZE_LOG2 = 8,
  parameter int unsigned COORD_BITS    = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tex_cmd_t                 in_cmd_i,
  input  logic [ScreenW-1:0]       screen_x_i,
  input  logic [ScreenW-1:0]       screen_y_i,
  input  cfg_t                     cfg_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tex_cmd_t                 out_cmd_o,
  output logic [TEX_SIZE_LOG2-1:0] col_o,
  output logic [TEX_SIZE_LOG2-1:0] row_o
);

  localparam int unsigned UseBits = (COORD_BITS < ScreenW) ? COORD_BITS : ScreenW;
  localparam logic [ScreenW-1:0] CoordMask = ScreenW'((1 << UseBits) - 1);
  localparam logic signed [AccW-1:0] Half =
    AccW'(1) <<< (TEX_SIZE_LOG2 + FracBits - 1);

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;
  tex_cmd_t cmd1_q, cmd2_q, cmd3_q;

  logic [ScreenW-1:0] sx, sy;
  logic signed [DeltaW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [CoefW-1:0] cos_z, sin_z;
  logic signed [ProdW-1:0] uc_d, vs_d, us_d, vc_d;
  logic signed [ProdW-1:0] uc_q, vs_q, us_q, vc_q;
  logic signed [AccW-1:0] u_acc, v_acc;
  logic [TEX_SIZE_LOG2-1:0] col_d, row_d, col_q, row_q;

  // A stage takes a new item when it is empty or its item moves on.
  assign r3 = !v3_q || out_ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  assign cos_z = cfg_i.cos_z;
  assign sin_z = cfg_i.sin_z;

  // Offsets from the center in half pixels.
  assign sx   = screen_x_i & CoordMask;
  assign sy   = screen_y_i & CoordMask;
  assign dx_d = DeltaW'({1'b0, sx, 1'b0}) - DeltaW'({1'b0, cfg_i.center_x});
  assign dy_d = DeltaW'({1'b0, sy, 1'b0}) - DeltaW'({1'b0, cfg_i.center_y});

  assign uc_d = dx_q * cos_z;
  assign vs_d = dy_q * sin_z;
  assign us_d = dx_q * sin_z;
  assign vc_d = dy_q * cos_z;

  assign u_acc = AccW'(uc_q) - AccW'(vs_q) + Half;
  assign v_acc = AccW'(us_q) + AccW'(vc_q) + Half;

  // Truncation toward zero: a negative value with a fraction rounds up by one.
  assign col_d = u_acc[FracBits +: TEX_SIZE_LOG2]
               + TEX_SIZE_LOG2'(u_acc[AccW-1] && (u_acc[FracBits-1:0] != '0));
  assign row_d = v_acc[FracBits +: TEX_SIZE_LOG2]
               + TEX_SIZE_LOG2'(v_acc[AccW-1] && (v_acc[FracBits-1:0] != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      cmd1_q <= in_cmd_i;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
    end
    if (r2) begin
      cmd2_q <= cmd1_q;
      uc_q   <= uc_d;
      vs_q   <= vs_d;
      us_q   <= us_d;
      vc_q   <= vc_d;
    end
    if (r3) begin
      cmd3_q <= cmd2_q;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_cmd_o   = cmd3_q;
  assign col_o       = col_q;
  assign row_o       = row_q;

endmodule

FILE: hw/rtl/rzm_texmem.sv
// Single-port texture memory with a registered read port.
`timescale 1ns / 1ps

module rzm_texmem import rzm_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  mem_ctrl_t         ctrl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [TexelW-1:0] wdata_i,
  output logic [TexelW-1:0] rdata_o
);

  logic [TexelW-1:0] mem_q [1 << ADDR_W];
  logic [TexelW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) mem_q[addr_i] <= wdata_i;
    if (ctrl_i.re) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
